/* rtl/line_start_index_core_defines.svh */
// ----------------------------------------------------------------------------
// Line start index: assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef LINE_START_INDEX_CORE_DEFINES_SVH
`define LINE_START_INDEX_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lsi_pkg.sv */
// ----------------------------------------------------------------------------
// Line start index: package
// Field widths, action and status codes and the command word type.
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned QUERY_W  = 32;
  localparam int unsigned RPOS_W   = 32;
  localparam int unsigned RLINE_W  = 13;
  localparam int unsigned RCOL_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // Command queue depth; must be a power of two.
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [ACTION_W-1:0] ACT_START     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TEXT      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POS_QUERY = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LC_QUERY  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_START,
    K_TEXT,
    K_FINISH,
    K_POS_QUERY,
    K_LC_QUERY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               newline;
    logic [QUERY_W-1:0] query_pos;
    logic [QUERY_W-1:0] query_line;
    logic [QUERY_W-1:0] query_col;
  } cmd_t;

  typedef struct packed {
    logic [RPOS_W-1:0]   result_pos;
    logic [RLINE_W-1:0]  result_line;
    logic [RCOL_W-1:0]   result_col;
    logic [STATUS_W-1:0] status;
  } res_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_POS_CLAMP,
    BK_SRCH_RD,
    BK_SRCH_CMP,
    BK_POS_FIN,
    BK_LC_LINE,
    BK_LC_RD2,
    BK_LC_SPAN,
    BK_LC_COL,
    BK_LC_FIN,
    BK_EMIT
  } back_state_e;

endpackage

/* rtl/lsi_if.sv */
// ----------------------------------------------------------------------------
// Line start index: channel interfaces
// Input item channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsi_in_if;
  logic                                valid;
  logic                                ready;
  logic [lsi_pkg::ACTION_W-1:0]        action;
  logic [lsi_pkg::BYTE_W-1:0]          data_byte;
  logic signed [lsi_pkg::QUERY_W-1:0]  query_pos;
  logic signed [lsi_pkg::QUERY_W-1:0]  query_line;
  logic signed [lsi_pkg::QUERY_W-1:0]  query_col;

  modport source (
    output valid, action, data_byte, query_pos, query_line, query_col,
    input  ready
  );
  modport sink (
    input  valid, action, data_byte, query_pos, query_line, query_col,
    output ready
  );
endinterface

interface lsi_out_if;
  logic                          valid;
  logic                          ready;
  logic [lsi_pkg::RPOS_W-1:0]    result_pos;
  logic [lsi_pkg::RLINE_W-1:0]   result_line;
  logic [lsi_pkg::RCOL_W-1:0]    result_col;
  logic [lsi_pkg::STATUS_W-1:0]  status;

  modport source (
    output valid, result_pos, result_line, result_col, status,
    input  ready
  );
  modport sink (
    input  valid, result_pos, result_line, result_col, status,
    output ready
  );
endinterface

/* rtl/lsi_front.sv */
// ----------------------------------------------------------------------------
// Line start index: front end
// Accepts input words, decodes the action and pushes commands to the queue.
// ----------------------------------------------------------------------------
module lsi_front (
  lsi_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output lsi_pkg::cmd_t   push_cmd_o
);
  import lsi_pkg::*;

  logic keep;

  assign in_i.ready = push_ready_i;

  always_comb begin
    keep               = 1'b1;
    push_cmd_o.kind    = K_START;
    push_cmd_o.newline = (in_i.data_byte == NEWLINE_BYTE);
    push_cmd_o.query_pos  = in_i.query_pos;
    push_cmd_o.query_line = in_i.query_line;
    push_cmd_o.query_col  = in_i.query_col;
    case (in_i.action)
      ACT_START:     push_cmd_o.kind = K_START;
      ACT_TEXT:      push_cmd_o.kind = K_TEXT;
      ACT_FINISH:    push_cmd_o.kind = K_FINISH;
      ACT_POS_QUERY: push_cmd_o.kind = K_POS_QUERY;
      ACT_LC_QUERY:  push_cmd_o.kind = K_LC_QUERY;
      default:       keep = 1'b0;
    endcase
  end

  // Unused action codes are accepted and dropped here.
  assign push_valid_o = in_i.valid && keep;

endmodule

/* rtl/lsi_queue.sv */
// ----------------------------------------------------------------------------
// Line start index: command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lsi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lsi_pkg::cmd_t  push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lsi_pkg::cmd_t  pop_cmd_o
);
  import lsi_pkg::*;

  localparam int unsigned QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

  cmd_t           slot_q [Q_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           push, pop;

  assign push_ready_o = (cnt_q != QCW'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/lsi_back.sv */
// ----------------------------------------------------------------------------
// Line start index: back end
// Builds the line-start table and answers position and line/column queries.
// ----------------------------------------------------------------------------
module lsi_back #(
  parameter int unsigned MAX_LINES = 4096,
  parameter int unsigned POS_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  lsi_pkg::cmd_t  pop_cmd_i,
  lsi_out_if.source      out_o
);
  import lsi_pkg::*;

  localparam int unsigned IW = $clog2(MAX_LINES);
  localparam int unsigned CW = $clog2(MAX_LINES + 1);
  localparam int unsigned AW = (POS_BITS + 2 > 34) ? POS_BITS + 2 : 34;
  localparam int unsigned LW = (IW + 1 > RLINE_W) ? IW + 1 : RLINE_W;
  localparam logic [CW-1:0] EC_NL_LIMIT = CW'(MAX_LINES - 1);
  localparam logic [CW-1:0] EC_MAX      = CW'(MAX_LINES);

  back_state_e state_q, state_d;

  logic [CW-1:0]       ec_q, ec_d;
  logic [POS_BITS-1:0] cnt_q, cnt_d;
  logic                ready_q, ready_d;
  logic                ovf_q, ovf_d;

  cmd_t                cmd_q, cmd_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [IW-1:0]       lo_q, lo_d;
  logic [IW-1:0]       hi_q, hi_d;
  logic [IW-1:0]       mid_q, mid_d;
  logic [POS_BITS-1:0] lo_val_q, lo_val_d;
  logic signed [AW-1:0] max_col_q, max_col_d;
  logic signed [AW-1:0] col_q, col_d;
  res_t                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic [POS_BITS-1:0] line_table_q [MAX_LINES];
  logic [POS_BITS-1:0] rd_data_q;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [POS_BITS-1:0] mem_wdata;
  logic [IW-1:0]       mem_raddr;

  logic [CW-1:0]       ec_m1;
  logic                pop;
  logic                out_load;
  logic                srch_done;

  assign ec_m1       = ec_q - CW'(1);
  assign pop_ready_o = (state_q == BK_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_load    = (state_q == BK_EMIT) && (!out_valid_q || out_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          case (pop_cmd_i.kind)
            K_POS_QUERY: state_d = ready_q ? BK_POS_CLAMP : BK_EMIT;
            K_LC_QUERY:  state_d = ready_q ? BK_LC_LINE : BK_EMIT;
            default:     state_d = BK_IDLE;
          endcase
        end
      end
      BK_POS_CLAMP: state_d = (ec_q <= CW'(2)) ? BK_POS_FIN : BK_SRCH_RD;
      BK_SRCH_RD:   state_d = BK_SRCH_CMP;
      BK_SRCH_CMP:  state_d = srch_done ? BK_POS_FIN : BK_SRCH_RD;
      BK_POS_FIN:   state_d = BK_EMIT;
      BK_LC_LINE:   state_d = BK_LC_RD2;
      BK_LC_RD2:    state_d = BK_LC_SPAN;
      BK_LC_SPAN:   state_d = BK_LC_COL;
      BK_LC_COL:    state_d = BK_LC_FIN;
      BK_LC_FIN:    state_d = BK_EMIT;
      BK_EMIT:      state_d = out_load ? BK_IDLE : BK_EMIT;
      default:      state_d = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic [POS_BITS-1:0]  cnt_inc;
    logic signed [AW-1:0] qv, sz, lcw, liw, span, cv, tw;
    logic [IW:0]          mid_sum;
    logic [IW-1:0]        lo_n, hi_n;
    logic [POS_BITS-1:0]  lv_n;
    logic                 found;
    logic [LW-1:0]        line_w;

    ec_d      = ec_q;
    cnt_d     = cnt_q;
    ready_d   = ready_q;
    ovf_d     = ovf_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    lo_val_d  = lo_val_q;
    max_col_d = max_col_q;
    col_d     = col_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = ec_q[IW-1:0];
    mem_wdata = cnt_q;
    mem_raddr = lo_q;
    srch_done = 1'b0;

    cnt_inc = (cnt_q != '1) ? cnt_q + POS_BITS'(1) : cnt_q;
    qv      = '0;
    sz      = '0;
    lcw     = '0;
    liw     = '0;
    span    = '0;
    cv      = '0;
    tw      = '0;
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    lo_n    = lo_q;
    hi_n    = hi_q;
    lv_n    = lo_val_q;
    found   = 1'b0;
    line_w  = LW'(lo_q) + LW'(1);

    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          case (pop_cmd_i.kind)
            K_START: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = '0;
              ec_d      = CW'(1);
              cnt_d     = '0;
              ready_d   = 1'b0;
              ovf_d     = 1'b0;
            end
            K_TEXT: begin
              if (ec_q != '0 && !ready_q) begin
                cnt_d = cnt_inc;
                if (pop_cmd_i.newline) begin
                  // The last slot stays free for the finish entry.
                  if (ec_q < EC_NL_LIMIT) begin
                    mem_we    = 1'b1;
                    mem_wdata = cnt_inc;
                    ec_d      = ec_q + CW'(1);
                  end else begin
                    ovf_d = 1'b1;
                  end
                end
              end
            end
            K_FINISH: begin
              if (ec_q != '0 && !ready_q) begin
                if (ec_q < EC_MAX) begin
                  mem_we = 1'b1;
                  ec_d   = ec_q + CW'(1);
                end
                ready_d = 1'b1;
              end
            end
            default: begin
              cmd_d = pop_cmd_i;
              res_d.result_pos  = '0;
              res_d.result_line = '0;
              res_d.result_col  = '0;
              res_d.status      = ST_NOT_READY;
            end
          endcase
        end
      end

      BK_POS_CLAMP: begin
        qv = AW'($signed(cmd_q.query_pos));
        sz = AW'(cnt_q);
        if (qv < 0) begin
          pos_d = '0;
        end else if (qv > sz) begin
          pos_d = cnt_q;
        end else begin
          pos_d = qv[POS_BITS-1:0];
        end
        lo_d     = '0;
        lo_val_d = '0;
        hi_d     = ec_m1[IW-1:0];
      end

      BK_SRCH_RD: begin
        mid_d     = mid_sum[IW:1];
        mem_raddr = mid_sum[IW:1];
      end

      BK_SRCH_CMP: begin
        if (rd_data_q < pos_q) begin
          lo_n = mid_q;
          lv_n = rd_data_q;
        end else if (rd_data_q > pos_q) begin
          hi_n = mid_q;
        end else begin
          lo_n  = mid_q;
          lv_n  = rd_data_q;
          found = 1'b1;
        end
        lo_d      = lo_n;
        hi_d      = hi_n;
        lo_val_d  = lv_n;
        srch_done = found || (({1'b0, lo_n} + (IW + 1)'(1)) >= {1'b0, hi_n});
      end

      BK_POS_FIN: begin
        tw = AW'(pos_q);
        res_d.result_pos  = tw[RPOS_W-1:0];
        res_d.result_line = line_w[RLINE_W-1:0];
        tw = AW'(pos_q) - AW'(lo_val_q) + AW'(1);
        res_d.result_col  = tw[RCOL_W-1:0];
        res_d.status      = ovf_q ? ST_OVERFLOW : ST_OK;
      end

      BK_LC_LINE: begin
        qv  = AW'($signed(cmd_q.query_line));
        lcw = AW'(ec_m1);
        if (qv > lcw) begin
          liw = lcw - AW'(1);
        end else if (qv < 1) begin
          liw = '0;
        end else begin
          liw = qv - AW'(1);
        end
        lo_d      = liw[IW-1:0];
        mem_raddr = liw[IW-1:0];
      end

      BK_LC_RD2: begin
        lo_val_d  = rd_data_q;
        mem_raddr = lo_q + IW'(1);
      end

      BK_LC_SPAN: begin
        span = AW'(rd_data_q) - AW'(lo_val_q);
        // The last line also owns the end-of-text position.
        if ((CW'(lo_q) + CW'(1)) == ec_m1) begin
          span = span + AW'(1);
        end
        if (span < 1) begin
          span = AW'(1);
        end
        max_col_d = span;
      end

      BK_LC_COL: begin
        cv = AW'($signed(cmd_q.query_col));
        if (cv < 0) begin
          if (-cv > max_col_q) begin
            cv = AW'(1);
          end else begin
            cv = max_col_q + cv + AW'(1);
          end
        end else if (cv == 0) begin
          cv = AW'(1);
        end else if (cv > max_col_q) begin
          cv = max_col_q;
        end
        col_d = cv;
      end

      BK_LC_FIN: begin
        tw = AW'(lo_val_q) + col_q - AW'(1);
        res_d.result_pos  = tw[RPOS_W-1:0];
        res_d.result_line = line_w[RLINE_W-1:0];
        res_d.result_col  = col_q[RCOL_W-1:0];
        res_d.status      = ovf_q ? ST_OVERFLOW : ST_OK;
      end

      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_pos  = out_q.result_pos;
  assign out_o.result_line = out_q.result_line;
  assign out_o.result_col  = out_q.result_col;
  assign out_o.status      = out_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ec_q        <= '0;
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ec_q        <= ec_d;
      cnt_q       <= cnt_d;
      ready_q     <= ready_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pos_q     <= pos_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    lo_val_q  <= lo_val_d;
    max_col_q <= max_col_d;
    col_q     <= col_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Line-start table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_table_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= line_table_q[mem_raddr];
  end

endmodule

/* rtl/line_start_index_core.sv */
// ----------------------------------------------------------------------------
// Line start index core
// Builds a line-start table from text bytes and maps positions to line and
// column and back.
//
//   channel  | dir | word contents
//   ---------+-----+-------------------------------------------------------
//   in_i     | in  | action, data_byte, query_pos, query_line, query_col
//   out_o    | out | result_pos, result_line, result_col, status
//
// Start, text and finish words do not hold the back end, so text streams at
// one byte per cycle while no query is in progress. A position query runs a
// binary search (steps: at most about log2 of the table entries); each step
// is a read of the single table read port plus a compare. A line/column
// query is bound by two successive reads of the same port.
// The table has no clearing pass after reset; a start word initializes it.
// A two-word command queue takes input while a query searches, until full.
// ----------------------------------------------------------------------------
module line_start_index_core #(
  parameter int unsigned MAX_LINES = 4096,
  parameter int unsigned POS_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsi_in_if.sink     in_i,
  lsi_out_if.source  out_o
);
  import lsi_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  lsi_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  lsi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  lsi_back #(
    .MAX_LINES (MAX_LINES),
    .POS_BITS  (POS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule

/* rtl/lsi_checker.sv */
// ----------------------------------------------------------------------------
// Line start index: port checker
// Watches the channels of the core and flags protocol and result slips.
// ----------------------------------------------------------------------------
`include "line_start_index_core_defines.svh"

module lsi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  lsi_in_if.sink    in_i,
  lsi_out_if.source out_o
);
  import lsi_pkg::*;

  logic [3:0] pend_q;
  logic       q_acc, r_acc;

  assign q_acc = in_i.valid && in_i.ready &&
                 (in_i.action == ACT_POS_QUERY || in_i.action == ACT_LC_QUERY);
  assign r_acc = out_o.valid && out_o.ready;

  // Queries accepted whose result word has not been taken yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (q_acc && !r_acc) begin
      pend_q <= pend_q + 4'd1;
    end else if (r_acc && !q_acc) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  `LSI_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.result_pos) && $stable(out_o.result_line) && $stable(out_o.result_col) && $stable(out_o.status), "result word changed while stalled")
  `LSI_ASSERT_NOW(a_out_has_query, out_o.valid, pend_q != 4'd0, "result word without a pending query")
  `LSI_ASSERT_NOW(a_not_ready_zero, out_o.valid && out_o.status == ST_NOT_READY, out_o.result_pos == '0 && out_o.result_line == '0 && out_o.result_col == '0, "not-ready result carries data")
  `LSI_ASSERT_NOW(a_status_code, out_o.valid, out_o.status == ST_OK || out_o.status == ST_NOT_READY || out_o.status == ST_OVERFLOW, "undefined status code")

endmodule

bind line_start_index_core lsi_checker u_lsi_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
